// ===== sv/fixed_key_value_table_defines.svh =====
// Assertion macros for the fixed key/value table.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef FIXED_KEY_VALUE_TABLE_DEFINES_SVH
`define FIXED_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define FKV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FKV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fkv_pkg.sv =====
// Shared types and constants for the fixed key/value table.
// No dependencies.
package fkv_pkg;

  localparam int unsigned ENTRIES     = 128;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned VALUE_BYTES = 8;
  localparam int unsigned KEY_W       = KEY_BYTES * 8;
  localparam int unsigned VAL_W       = VALUE_BYTES * 8;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] new_value;
  } fkv_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
  } fkv_rsp_t;

  // Operation broadcast to every cell while a scan runs.
  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } fkv_op_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             active;
    logic             hit;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic [VAL_W-1:0] rd;
  } fkv_tok_t;

  // Create write issued after a scan that found no match.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } fkv_wr_t;

endpackage

// ===== sv/fkv_cell.sv =====
// One table entry of the search chain: key, value, valid mark and token stage.
// Depends on fkv_pkg.
module fkv_cell import fkv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  fkv_op_t          op_i,
  input  fkv_wr_t          wr_i,
  input  fkv_tok_t         tok_i,
  output fkv_tok_t         tok_o
);

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q, val_d;
  logic             valid_q, valid_d;
  logic             key_we;
  logic             match;
  fkv_tok_t         tok_d, tok_q;

  assign match = tok_i.active && valid_q && (key_q == op_i.key);
  assign key_we = wr_i.en && (wr_i.idx == idx_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (key_we) begin
      val_d   = wr_i.value;
      valid_d = 1'b1;
    end else if (match) begin
      if (op_i.kind == KIND_SET) begin
        val_d = op_i.value;
      end
      if (op_i.kind == KIND_DEL) begin
        valid_d = 1'b0;
      end
    end
  end

  always_comb begin
    tok_d        = tok_i;
    tok_d.hit    = tok_i.hit | match;
    if (match) begin
      tok_d.rd = val_q;
    end
    // Record the lowest free entry seen so far.
    if (tok_i.active && !valid_q && !tok_i.free_seen) begin
      tok_d.free_seen = 1'b1;
      tok_d.free_idx  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (key_we) begin
      key_q <= wr_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/fixed_key_value_table.sv =====
// Top level of the fixed key/value table: command control and the cell chain.
// Depends on fkv_pkg, fkv_cell and fixed_key_value_table_defines.svh.
//
//   channel   signals                  transfer when
//   request   start_i, req_i, busy_o   start_i && !busy_o
//   response  rsp_valid_o, rsp_o       rsp_valid_o (one cycle, no backpressure)
//
// For each command a search token walks the cell chain one entry per cycle,
// then the result is registered and busy_o drops, allowing the next transfer.
// A create writes the free entry in the cycle the token leaves the last cell.
// Reset clears all valid marks at once; no clearing pass is needed.
// The receiver cannot stall; busy_o is the only back pressure.
module fixed_key_value_table import fkv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  fkv_req_t req_i,
  output logic     busy_o,
  output logic     rsp_valid_o,
  output fkv_rsp_t rsp_o
);

  `include "fixed_key_value_table_defines.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]   state_q, state_d;
  logic         launch_q, launch_d;
  logic         accept;
  fkv_op_t      op_q;
  fkv_rsp_t     rsp_q, rsp_d;
  fkv_wr_t      wr;
  fkv_tok_t     tok [ENTRIES+1];
  fkv_tok_t     tok_end;
  logic [ENTRIES-1:0] tok_act;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    tok[0]           = '0;
    tok[0].active    = launch_q;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fkv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(i)),
      .op_i   (op_q),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
    assign tok_act[i] = tok[i+1].active;
  end

  assign tok_end = tok[ENTRIES];

  // Create on a set that missed and found a free entry.
  always_comb begin
    wr.en    = tok_end.active && (op_q.kind == KIND_SET) && !tok_end.hit &&
               tok_end.free_seen;
    wr.idx   = tok_end.free_idx;
    wr.key   = op_q.key;
    wr.value = op_q.value;
  end

  always_comb begin
    rsp_d            = '0;
    rsp_d.status     = ST_NOT_FOUND;
    unique case (op_q.kind)
      KIND_SET: begin
        if (tok_end.hit) begin
          rsp_d.status = ST_UPDATED;
        end else if (tok_end.free_seen) begin
          rsp_d.status = ST_CREATED;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      KIND_GET: begin
        if (tok_end.hit) begin
          rsp_d.status     = ST_FOUND;
          rsp_d.read_value = 64'(tok_end.rd);
        end
      end
      KIND_DEL: begin
        if (tok_end.hit) begin
          rsp_d.status = ST_DELETED;
        end
      end
      default: rsp_d.status = ST_NOT_FOUND;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_SCAN;
          launch_d = 1'b1;
        end
      end
      S_SCAN: begin
        if (tok_end.active) begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q.kind  <= req_i.kind;
      op_q.key   <= req_i.key[KEY_W-1:0];
      op_q.value <= req_i.new_value[VAL_W-1:0];
    end
    if (tok_end.active) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);
  assign rsp_o       = rsp_q;

  `FKV_ASSERT_NXT(a_accept_busy, accept, busy_o && !rsp_valid_o,
                  "accepted command did not raise busy")
  `FKV_ASSERT_NXT(a_end_rsp, tok_end.active, rsp_valid_o,
                  "scan end not followed by a response")
  `FKV_ASSERT_IMP(a_one_token, 1'b1, $onehot0({tok_act, launch_q}),
                  "more than one search token in the chain")
  `FKV_ASSERT_IMP(a_wr_scan, wr.en, state_q == S_SCAN && op_q.kind == KIND_SET,
                  "create write outside a set scan")

endmodule
